// ----- hw/rtl/msd_pkg.sv -----
// shared types, constants and helper functions of the seven-segment driver
`default_nettype none

package msd_pkg;

    // operation codes of a request word
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_NUMBER = 2'd1,
        OP_DIGIT  = 2'd2,
        OP_BLANK  = 2'd3
    } op_t;

    localparam int unsigned NUM_W  = 14;
    localparam int unsigned CODE_W = 5;
    localparam int unsigned SEG_W  = 7;
    localparam int unsigned ENA_W  = 4;
    localparam int unsigned SCAN_W = 2;

    localparam longint unsigned NUM_MAX = 64'd16383;

    localparam logic [CODE_W-1:0] BLANK_CODE = 5'd16;
    // first code that is rejected by set-digit
    localparam logic [CODE_W:0]   CODE_LIMIT = 6'd17;

    typedef struct packed {
        op_t               operation;
        logic [NUM_W-1:0]  number_value;
        logic [2:0]        digit_position;
        logic [CODE_W-1:0] digit_code;
    } req_word_t;

    typedef struct packed {
        logic [SEG_W-1:0]  segment_lines;
        logic [ENA_W-1:0]  digit_enable;
        logic [SCAN_W-1:0] scan_position;
        logic              request_error;
    } rsp_word_t;

    // elaboration-time power of ten
    function automatic longint unsigned pow10(input int unsigned n);
        longint unsigned p;
        p = 64'd1;
        for (int unsigned i = 0; i < n; i++)
        begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    // active-high hex glyphs, bit 0 is segment a; blank and unused codes dark
    function automatic logic [SEG_W-1:0] glyph(input logic [CODE_W-1:0] code);
        logic [SEG_W-1:0] pat;
        case (code)
            5'd0:    pat = 7'h3F;
            5'd1:    pat = 7'h06;
            5'd2:    pat = 7'h5B;
            5'd3:    pat = 7'h4F;
            5'd4:    pat = 7'h66;
            5'd5:    pat = 7'h6D;
            5'd6:    pat = 7'h7D;
            5'd7:    pat = 7'h07;
            5'd8:    pat = 7'h7F;
            5'd9:    pat = 7'h6F;
            5'd10:   pat = 7'h77;
            5'd11:   pat = 7'h7C;
            5'd12:   pat = 7'h39;
            5'd13:   pat = 7'h5E;
            5'd14:   pat = 7'h79;
            5'd15:   pat = 7'h71;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/msd_decimal_split.sv -----
// binary to decimal digit split by constant reciprocal multiplication
`default_nettype none

module msd_decimal_split #(
    parameter int unsigned DIGITS = 4
) (
    input  wire logic [msd_pkg::NUM_W-1:0] number,
    output logic [DIGITS-1:0][3:0]         digits,
    output logic                           in_range
);
    import msd_pkg::*;

    localparam int unsigned MUL_S  = 30;
    localparam int unsigned PROD_W = NUM_W + MUL_S;
    localparam longint unsigned LIMIT = pow10(DIGITS);

    // q[i] = number / 10^i
    logic [DIGITS:0][NUM_W-1:0] q;

    for (genvar i = 0; i <= DIGITS; i++)
    begin : g_quot
        localparam longint unsigned P = pow10(i);
        if (i == 0)
        begin : g_unit
            assign q[i] = number;
        end
        else if (P > NUM_MAX)
        begin : g_zero
            assign q[i] = '0;
        end
        else
        begin : g_mul
            localparam longint unsigned M = ((64'd1 << MUL_S) / P) + 64'd1;
            logic [PROD_W-1:0] prod;
            assign prod = PROD_W'(number) * PROD_W'(M);
            assign q[i] = prod[MUL_S +: NUM_W];
        end
    end

    for (genvar i = 0; i < DIGITS; i++)
    begin : g_digit
        logic [NUM_W-1:0] rem;
        assign rem       = q[i] - ((q[i+1] << 3) + (q[i+1] << 1));
        assign digits[i] = rem[3:0];
    end

    if (LIMIT > NUM_MAX)
    begin : g_no_limit
        assign in_range = 1'b1;
    end
    else
    begin : g_limit
        assign in_range = (number < NUM_W'(LIMIT));
    end

endmodule

`default_nettype wire

// ----- hw/rtl/msd_display_state.sv -----
// digit code store, scan position and result word formation
`default_nettype none

module msd_display_state #(
    parameter int unsigned DIGITS = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  wire msd_pkg::req_word_t    item,
    input  wire logic [DIGITS-1:0][3:0] digits,
    input  wire logic                  num_ok,
    output msd_pkg::rsp_word_t         result
);
    import msd_pkg::*;

    localparam int unsigned POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    logic [DIGITS-1:0][CODE_W-1:0] codes_reg;
    logic [DIGITS-1:0][CODE_W-1:0] codes_next;
    logic [POS_W-1:0]              pos_reg;
    logic [POS_W-1:0]              pos_next;
    logic                          err;
    logic [2:0]                    pos_ext;

    always_comb
    begin
        codes_next = codes_reg;
        pos_next   = pos_reg;
        err        = 1'b0;
        case (item.operation)
            OP_TICK:
            begin
                if (pos_reg == POS_W'(DIGITS - 1))
                    pos_next = '0;
                else
                    pos_next = POS_W'(pos_reg + 1'b1);
            end
            OP_NUMBER:
            begin
                if (!num_ok)
                    err = 1'b1;
                else
                    for (int e = 0; e < DIGITS; e++)
                    begin
                        codes_next[e] = {1'b0, digits[e]};
                    end
            end
            OP_DIGIT:
            begin
                if (({1'b0, item.digit_position} >= 4'(DIGITS)) ||
                    ({1'b0, item.digit_code} >= CODE_LIMIT))
                    err = 1'b1;
                else
                    for (int e = 0; e < DIGITS; e++)
                    begin
                        if (item.digit_position == 3'(e))
                            codes_next[e] = item.digit_code;
                    end
            end
            OP_BLANK:
            begin
                for (int e = 0; e < DIGITS; e++)
                begin
                    codes_next[e] = BLANK_CODE;
                end
            end
            default:
            begin
                err = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int e = 0; e < DIGITS; e++)
            begin
                codes_reg[e] <= BLANK_CODE;
            end
        end
        else if (advance)
        begin
            pos_reg   <= pos_next;
            codes_reg <= codes_next;
        end
    end

    // outputs show the state after this word, so writes appear at once
    assign pos_ext = 3'(pos_next);

    always_comb
    begin
        result.segment_lines = glyph(codes_next[pos_next]);
        for (int k = 0; k < ENA_W; k++)
        begin
            result.digit_enable[k] = (pos_ext == 3'(k));
        end
        result.scan_position = pos_ext[SCAN_W-1:0];
        result.request_error = err;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/multiplexed_seven_segment_driver.sv -----
// top level of the multiplexed seven-segment display driver
//
// usage:
//   req channel (req_valid/req_ready/req_word) takes one word per operation:
//   scan tick, set decimal number, set one digit or blank all. every word
//   gives exactly one rsp word (rsp_valid/rsp_ready/rsp_word) with the
//   segment pattern, one-hot digit enable and index of the scanned position
//   after that word, plus an error flag for rejected requests.
// path: an accepted word is held in the input register, moves to the
//   result register once that is free or being drained, and shows on rsp
//   from then on until the receiver takes it.
// throughput: one word per cycle while rsp_ready is high; the decimal split and the glyph
//   lookup are single-pass logic between the two registers.
// reset: all positions hold the blank code, scan position 0, no word held.
// stall: the result register holds its word while rsp_ready is low; one
//   more word can wait in the input register, after which req_ready drops
//   until the result word is taken. req_ready depends on rsp_ready.
`default_nettype none

module multiplexed_seven_segment_driver #(
    parameter int unsigned DIGITS = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire msd_pkg::req_word_t req_word,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output msd_pkg::rsp_word_t      rsp_word
);
    import msd_pkg::*;

    // input register
    logic      s1_valid_reg;
    req_word_t s1_word_reg;
    // result register
    logic      rsp_valid_reg;
    rsp_word_t rsp_word_reg;

    logic                   s1_advance;
    logic [DIGITS-1:0][3:0] digits;
    logic                   num_ok;
    rsp_word_t              result;

    // the input word moves on when the result register is free or drains
    assign s1_advance = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready  = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
                s1_valid_reg <= req_valid;
            if (s1_advance)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
            s1_word_reg <= req_word;
        if (s1_advance)
            rsp_word_reg <= result;
    end

    msd_decimal_split #(
        .DIGITS (DIGITS)
    ) u_split (
        .number   (s1_word_reg.number_value),
        .digits   (digits),
        .in_range (num_ok)
    );

    // state updates only when the word is committed to the result register
    msd_display_state #(
        .DIGITS (DIGITS)
    ) u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_advance),
        .item    (s1_word_reg),
        .digits  (digits),
        .num_ok  (num_ok),
        .result  (result)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/msd_checker.sv -----
// port-level checks of the seven-segment driver, bound to the top level
`default_nettype none

module msd_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_ready,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire msd_pkg::rsp_word_t rsp_word
);
    import msd_pkg::*;

    // a stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
        else $error("rsp word changed while stalled");

    // an empty result register never blocks the request side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("req_ready low with empty result register");

    // a lit enable always points at the reported scan position
    a_enable_matches: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_word.digit_enable != 4'd0) |->
            rsp_word.digit_enable == (4'd1 << rsp_word.scan_position))
        else $error("digit enable does not match scan position");

    // enable is never more than one position
    a_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot0(rsp_word.digit_enable))
        else $error("more than one digit enabled");

endmodule

bind multiplexed_seven_segment_driver msd_checker u_msd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word)
);

`default_nettype wire
